// ----- design/sfr_pkg.sv -----
package sfr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int LINE_BITS       = 24;
    localparam int COLUMN_BITS     = 16;

    localparam int CFG_WORD_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int LEN_FIELD_BITS = 4;

    localparam int PLEN_BITS = $clog2(MAX_PATTERN + 1);
    localparam int RLEN_BITS = $clog2(MAX_REPLACEMENT + 1);
    localparam int FILL_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam int JOB_BYTES = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
    localparam int NB_BITS   = $clog2(JOB_BYTES + 1);
    localparam int POS_BITS  = $clog2(JOB_BYTES + 2);
    localparam int IDX_BITS  = (JOB_BYTES > 1) ? $clog2(JOB_BYTES) : 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] NEWLINE = 8'h0A;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PATTERN_BYTES      = 3'd0,
        REG_PATTERN_LENGTH     = 3'd1,
        REG_REPLACEMENT_BYTES  = 3'd2,
        REG_REPLACEMENT_LENGTH = 3'd3,
        REG_REPLACE_ENABLE     = 3'd4,
        REG_REPORT_ENABLE      = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        ITEM_DATA   = 1'b0,
        ITEM_REPORT = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [CFG_WORD_BITS-1:0] pattern;
        logic [PLEN_BITS-1:0]     plen;
        logic [CFG_WORD_BITS-1:0] replacement;
        logic [RLEN_BITS-1:0]     rlen;
        logic                     replace_en;
        logic                     report_en;
    } cfg_t;

    typedef struct packed {
        logic                     report;
        logic [LINE_BITS-1:0]     line;
        logic [COLUMN_BITS-1:0]   column;
        logic [NB_BITS-1:0]       nbytes;
        logic [8*JOB_BYTES-1:0]   bytes;
    } job_t;

endpackage

// ----- design/sfr_cfg.sv -----
module sfr_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [sfr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sfr_pkg::CFG_WORD_BITS-1:0]   cfg_data,
    output sfr_pkg::cfg_t                       cfg,
    output logic                                win_clear
);
    import sfr_pkg::*;

    logic [CFG_WORD_BITS-1:0]  pattern_reg,  pattern_next;
    logic [LEN_FIELD_BITS-1:0] plen_raw_reg, plen_raw_next;
    logic [CFG_WORD_BITS-1:0]  repl_reg,     repl_next;
    logic [LEN_FIELD_BITS-1:0] rlen_raw_reg, rlen_raw_next;
    logic                      replace_reg,  replace_next;
    logic                      report_reg,   report_next;

    always_comb
    begin
        pattern_next  = pattern_reg;
        plen_raw_next = plen_raw_reg;
        repl_next     = repl_reg;
        rlen_raw_next = rlen_raw_reg;
        replace_next  = replace_reg;
        report_next   = report_reg;
        win_clear     = 1'b0;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_BYTES:
                begin
                    pattern_next = cfg_data;
                    win_clear    = 1'b1;
                end
                REG_PATTERN_LENGTH:
                begin
                    plen_raw_next = cfg_data[LEN_FIELD_BITS-1:0];
                    win_clear     = 1'b1;
                end
                REG_REPLACEMENT_BYTES:  repl_next     = cfg_data;
                REG_REPLACEMENT_LENGTH: rlen_raw_next = cfg_data[LEN_FIELD_BITS-1:0];
                REG_REPLACE_ENABLE:     replace_next  = cfg_data[0];
                REG_REPORT_ENABLE:      report_next   = cfg_data[0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg  <= '0;
            plen_raw_reg <= LEN_FIELD_BITS'(1);
            repl_reg     <= '0;
            rlen_raw_reg <= '0;
            replace_reg  <= 1'b0;
            report_reg   <= 1'b0;
        end
        else
        begin
            pattern_reg  <= pattern_next;
            plen_raw_reg <= plen_raw_next;
            repl_reg     <= repl_next;
            rlen_raw_reg <= rlen_raw_next;
            replace_reg  <= replace_next;
            report_reg   <= report_next;
        end
    end

    always_comb
    begin
        cfg.pattern     = pattern_reg;
        cfg.replacement = repl_reg;
        cfg.replace_en  = replace_reg;
        cfg.report_en   = report_reg;
        if (plen_raw_reg == '0)
            cfg.plen = PLEN_BITS'(1);
        else if (plen_raw_reg > LEN_FIELD_BITS'(MAX_PATTERN))
            cfg.plen = PLEN_BITS'(MAX_PATTERN);
        else
            cfg.plen = PLEN_BITS'(plen_raw_reg);
        if (rlen_raw_reg > LEN_FIELD_BITS'(MAX_REPLACEMENT))
            cfg.rlen = RLEN_BITS'(MAX_REPLACEMENT);
        else
            cfg.rlen = RLEN_BITS'(rlen_raw_reg);
    end

endmodule

// ----- design/sfr_front.sv -----
module sfr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          final_byte,
    input  sfr_pkg::cfg_t cfg,
    input  logic          win_clear,
    input  logic          q_full,
    output logic          push,
    output sfr_pkg::job_t job
);
    import sfr_pkg::*;

    logic [7:0]             win_byte_reg [MAX_PATTERN];
    logic [7:0]             win_byte_next[MAX_PATTERN];
    logic [LINE_BITS-1:0]   win_line_reg [MAX_PATTERN];
    logic [LINE_BITS-1:0]   win_line_next[MAX_PATTERN];
    logic [COLUMN_BITS-1:0] win_col_reg  [MAX_PATTERN];
    logic [COLUMN_BITS-1:0] win_col_next [MAX_PATTERN];
    logic [FILL_BITS-1:0]   fill_reg, fill_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg,  col_next;

    logic [7:0]             ext_byte[MAX_PATTERN];
    logic [LINE_BITS-1:0]   ext_line[MAX_PATTERN];
    logic [COLUMN_BITS-1:0] ext_col [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] pre;
    logic [PLEN_BITS-1:0]   n;
    logic [PLEN_BITS-1:0]   pop_cnt;
    logic                   match;
    logic                   accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign n        = PLEN_BITS'(fill_reg) + PLEN_BITS'(1);

    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (PLEN_BITS'(j) == PLEN_BITS'(fill_reg))
            begin
                ext_byte[j] = in_byte;
                ext_line[j] = line_reg;
                ext_col[j]  = col_reg;
            end
            else
            begin
                ext_byte[j] = win_byte_reg[j];
                ext_line[j] = win_line_reg[j];
                ext_col[j]  = win_col_reg[j];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            pre[k] = 1'b1;
            for (int j = 0; j < MAX_PATTERN - k; j++)
            begin
                if (PLEN_BITS'(k + j) < n && ext_byte[k + j] != cfg.pattern[8*j +: 8])
                    pre[k] = 1'b0;
            end
        end
        match = (n == cfg.plen) && pre[0];
        pop_cnt = n;
        for (int k = MAX_PATTERN - 1; k >= 0; k--)
        begin
            if (PLEN_BITS'(k) <= n && pre[k] && (n - PLEN_BITS'(k)) < cfg.plen)
                pop_cnt = PLEN_BITS'(k);
        end
        if (final_byte)
            pop_cnt = n;
    end

    always_comb
    begin
        job.report = match && cfg.report_en;
        job.line   = ext_line[0];
        job.column = ext_col[0];
        job.bytes  = '0;
        if (match)
        begin
            job.bytes  = (8*JOB_BYTES)'(cfg.replacement);
            job.nbytes = cfg.replace_en ? NB_BITS'(cfg.rlen) : '0;
        end
        else
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
                job.bytes[8*j +: 8] = ext_byte[j];
            job.nbytes = cfg.replace_en ? NB_BITS'(pop_cnt) : '0;
        end
        push = accept && (job.report || job.nbytes != '0);
    end

    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            win_byte_next[j] = ext_byte[j];
            win_line_next[j] = ext_line[j];
            win_col_next[j]  = ext_col[j];
            for (int k = 1; k < MAX_PATTERN - j; k++)
            begin
                if (pop_cnt == PLEN_BITS'(k))
                begin
                    win_byte_next[j] = ext_byte[j + k];
                    win_line_next[j] = ext_line[j + k];
                    win_col_next[j]  = ext_col[j + k];
                end
            end
        end

        fill_next = fill_reg;
        line_next = line_reg;
        col_next  = col_reg;
        if (accept)
        begin
            if (match)
                fill_next = '0;
            else
                fill_next = FILL_BITS'(n - pop_cnt);
            if (final_byte)
            begin
                line_next = LINE_BITS'(1);
                col_next  = COLUMN_BITS'(1);
            end
            else if (in_byte == NEWLINE)
            begin
                if (line_reg != '1)
                    line_next = line_reg + LINE_BITS'(1);
                col_next = COLUMN_BITS'(1);
            end
            else if (col_reg != '1)
            begin
                col_next = col_reg + COLUMN_BITS'(1);
            end
        end
        if (win_clear)
            fill_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                win_byte_reg[j] <= win_byte_next[j];
                win_line_reg[j] <= win_line_next[j];
                win_col_reg[j]  <= win_col_next[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            line_reg <= LINE_BITS'(1);
            col_reg  <= COLUMN_BITS'(1);
        end
        else
        begin
            fill_reg <= fill_next;
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_below_plen: assert property (@(posedge clk) disable iff (!rst_n)
        PLEN_BITS'(fill_reg) < cfg.plen)
        else $error("window fill reached pattern length");

    a_final_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && final_byte && !win_clear |=>
            fill_reg == '0 && line_reg == LINE_BITS'(1) && col_reg == COLUMN_BITS'(1))
        else $error("final byte did not flush window and counters");
`endif

endmodule

// ----- design/sfr_queue.sv -----
module sfr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sfr_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output sfr_pkg::job_t head_data
);
    import sfr_pkg::*;

    job_t                 mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg,  count_next;

    assign full       = count_reg == QCNT_BITS'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");
`endif

endmodule

// ----- design/sfr_back.sv -----
module sfr_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             head_valid,
    input  sfr_pkg::job_t                    head_data,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             item_kind,
    output logic [7:0]                       out_byte,
    output logic [sfr_pkg::LINE_BITS-1:0]    match_line,
    output logic [sfr_pkg::COLUMN_BITS-1:0]  match_column,
    output logic                             run_end
);
    import sfr_pkg::*;

    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic                   valid_reg, valid_next;
    logic                   kind_reg, kind_next;
    logic [7:0]             byte_reg, byte_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg,  col_next;
    logic                   end_reg,  end_next;

    logic [POS_BITS-1:0]    total;
    logic [POS_BITS-1:0]    byte_pos;
    logic                   last;
    logic                   load;

    assign total    = POS_BITS'(head_data.report) + POS_BITS'(head_data.nbytes);
    assign byte_pos = pos_reg - POS_BITS'(head_data.report);
    assign last     = pos_reg == total - POS_BITS'(1);
    assign load     = head_valid && (!valid_reg || out_ready);
    assign pop      = load && last;

    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg && !out_ready;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        end_next   = end_reg;
        if (load)
        begin
            valid_next = 1'b1;
            pos_next   = last ? '0 : pos_reg + POS_BITS'(1);
            end_next   = last;
            if (head_data.report && pos_reg == '0)
            begin
                kind_next = ITEM_REPORT;
                byte_next = '0;
                line_next = head_data.line;
                col_next  = head_data.column;
            end
            else
            begin
                kind_next = ITEM_DATA;
                byte_next = head_data.bytes[8*byte_pos[IDX_BITS-1:0] +: 8];
                line_next = '0;
                col_next  = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        line_reg <= line_next;
        col_reg  <= col_next;
        end_reg  <= end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid    = valid_reg;
    assign item_kind    = kind_reg;
    assign out_byte     = byte_reg;
    assign match_line   = line_reg;
    assign match_column = col_reg;
    assign run_end      = end_reg;

`ifndef NO_ASSERTIONS
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> pos_reg < total)
        else $error("item position beyond queued entry");

    a_report_position: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && kind_reg == ITEM_REPORT |-> line_reg != '0 && col_reg != '0)
        else $error("report carries zero line or column");
`endif

endmodule

// ----- design/stream_find_replace.sv -----
// channel  | direction | signals
// ---------+-----------+-----------------------------------------------------------
// in       | sink      | in_valid, in_ready, in_byte, final_byte
// out      | source    | out_valid, out_ready, item_kind, out_byte, match_line,
//          |           | match_column, run_end
// cfg      | sink      | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One input byte per cycle, while the job queue is not full, is classified against the window combinationally.
// Each byte yields 0 to 9 results; the output stage sends one result per cycle
// while out_ready is high and the job queue holds an entry.
// A 4-entry job queue between classifier and output lets the input run ahead.
// Reset: line 1, column 1, empty window, registers at their reset values.
// in_ready drops only while the job queue is full; cfg_ready is always high.
module stream_find_replace (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          in_byte,
    input  logic                                final_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                item_kind,
    output logic [7:0]                          out_byte,
    output logic [sfr_pkg::LINE_BITS-1:0]       match_line,
    output logic [sfr_pkg::COLUMN_BITS-1:0]     match_column,
    output logic                                run_end,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sfr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sfr_pkg::CFG_WORD_BITS-1:0]   cfg_data
);
    import sfr_pkg::*;

    cfg_t cfg;
    logic win_clear;
    logic q_full;
    logic push;
    job_t job;
    logic pop;
    logic head_valid;
    job_t head_data;

    assign cfg_ready = 1'b1;

    sfr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .win_clear (win_clear)
    );

    sfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .cfg        (cfg),
        .win_clear  (win_clear),
        .q_full     (q_full),
        .push       (push),
        .job        (job)
    );

    sfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    sfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .item_kind    (item_kind),
        .out_byte     (out_byte),
        .match_line   (match_line),
        .match_column (match_column),
        .run_end      (run_end)
    );

endmodule
